// ===== rtl/core/asde_pkg.sv =====
// ----------------------------------------------------------------------------
// asde_pkg
// Shared types and constants for the linear envelope generator: phase codes,
// gain selection codes, configuration register indexes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package asde_pkg;

  localparam int LEVEL_BITS     = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int DIV_STEPS      = LEVEL_BITS;
  localparam int DIV_COUNT_BITS = $clog2(DIV_STEPS);

  localparam logic [LEVEL_BITS-1:0] UNITY = 16'h8000;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_ATTACK  = 2'd0;
  localparam phase_t PH_SUSTAIN = 2'd1;
  localparam phase_t PH_DECAY   = 2'd2;
  localparam phase_t PH_DONE    = 2'd3;

  typedef logic [1:0] gain_kind_t;
  localparam gain_kind_t GK_RAMP  = 2'd0;
  localparam gain_kind_t GK_LEVEL = 2'd1;
  localparam gain_kind_t GK_ZERO  = 2'd2;
  localparam gain_kind_t GK_PASS  = 2'd3;

  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  localparam cfg_index_t CFG_ATTACK_END  = 2'd0;
  localparam cfg_index_t CFG_DECAY_START = 2'd1;
  localparam cfg_index_t CFG_END         = 2'd2;
  localparam cfg_index_t CFG_LEVEL       = 2'd3;

  typedef struct packed {
    logic load_in;
    logic decide;
    logic mul;
    logic div_step;
    logic scale;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/asde_ctrl.sv =====
// ----------------------------------------------------------------------------
// asde_ctrl
// Sequencer for one sample: capture, phase decision, for ramp samples the
// ramp product and serial division, sample scaling and output hand-off.
// ----------------------------------------------------------------------------
module asde_ctrl
  import asde_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output logic    in_stall,
  output cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_SCALE  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0]                state;
  logic [2:0]                state_next;
  logic [DIV_COUNT_BITS-1:0] div_count;
  logic [DIV_COUNT_BITS-1:0] div_count_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    div_count_next = div_count;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.need_div ? S_MUL : S_SCALE;
      end
      S_MUL: begin
        cmd.mul        = 1'b1;
        div_count_next = '0;
        state_next     = S_DIV;
      end
      S_DIV: begin
        cmd.div_step   = 1'b1;
        div_count_next = div_count + 1'b1;
        if (div_count == DIV_COUNT_BITS'(DIV_STEPS - 1)) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_count <= '0;
    end else begin
      state     <= state_next;
      div_count <= div_count_next;
    end
  end

endmodule

// ===== rtl/core/asde_dp.sv =====
// ----------------------------------------------------------------------------
// asde_dp
// Datapath: configuration registers, envelope phase, ramp multiplier,
// restoring divider, sample multiplier and the output register.
// ----------------------------------------------------------------------------
module asde_dp
  import asde_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAME_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  output status_t                       status,
  input  logic [FRAME_BITS-1:0]         frame_index,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          last_in,
  input  logic                          cfg_write,
  input  cfg_index_t                    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          finished,
  output logic                          last_out
);

  localparam int PROD_BITS  = LEVEL_BITS + FRAME_BITS;
  localparam int SCALE_BITS = SAMPLE_BITS + LEVEL_BITS + 1;

  logic [FRAME_BITS-1:0]         attack_end;
  logic [FRAME_BITS-1:0]         decay_start;
  logic [FRAME_BITS-1:0]         end_frame;
  logic [LEVEL_BITS-1:0]         sustain_level;
  phase_t                        phase;

  logic [FRAME_BITS-1:0]         frame_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          last_r;

  gain_kind_t                    kind;
  logic [FRAME_BITS-1:0]         operand;
  logic [FRAME_BITS-1:0]         divisor;
  logic [LEVEL_BITS-1:0]         gain;
  logic [FRAME_BITS-1:0]         rem;
  logic [LEVEL_BITS-1:0]         quot;
  logic signed [SCALE_BITS-1:0]  scaled;

  logic [LEVEL_BITS-1:0]         level;
  phase_t                        phase_next;
  gain_kind_t                    kind_next;
  logic [FRAME_BITS-1:0]         operand_next;
  logic [FRAME_BITS-1:0]         divisor_next;
  logic                          have_gain;
  logic [PROD_BITS-1:0]          ramp_prod;
  logic [FRAME_BITS:0]           trial;
  logic                          trial_ge;
  logic [LEVEL_BITS-1:0]         gain_sel;

  assign level = (sustain_level > UNITY) ? UNITY : sustain_level;

  always_comb begin
    phase_next   = phase;
    kind_next    = GK_PASS;
    operand_next = frame_r;
    divisor_next = attack_end;
    have_gain    = 1'b0;
    if (phase_next == PH_ATTACK) begin
      if (frame_r < attack_end) begin
        kind_next = GK_RAMP;
        have_gain = 1'b1;
      end else begin
        phase_next = PH_SUSTAIN;
      end
    end
    if (!have_gain && phase_next == PH_SUSTAIN) begin
      if (frame_r < decay_start) begin
        kind_next = GK_LEVEL;
        have_gain = 1'b1;
      end else begin
        phase_next = PH_DECAY;
      end
    end
    if (!have_gain && phase_next == PH_DECAY) begin
      if (frame_r < end_frame) begin
        have_gain = 1'b1;
        if (frame_r < decay_start) begin
          kind_next = GK_ZERO;
        end else begin
          kind_next    = GK_RAMP;
          operand_next = end_frame - frame_r;
          divisor_next = end_frame - decay_start;
        end
      end else begin
        phase_next = PH_DONE;
      end
    end
  end

  assign status.need_div = (kind_next == GK_RAMP);
  assign status.out_free = !out_valid || !out_stall;

  assign ramp_prod = PROD_BITS'(level) * PROD_BITS'(operand);
  assign trial     = {rem, quot[LEVEL_BITS-1]};
  assign trial_ge  = (trial >= {1'b0, divisor});
  assign gain_sel  = (kind == GK_RAMP) ? quot : gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_end    <= '0;
      decay_start   <= '0;
      end_frame     <= '0;
      sustain_level <= UNITY;
      phase         <= PH_ATTACK;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ATTACK_END:  attack_end    <= cfg_data[FRAME_BITS-1:0];
        CFG_DECAY_START: decay_start   <= cfg_data[FRAME_BITS-1:0];
        CFG_END:         end_frame     <= cfg_data[FRAME_BITS-1:0];
        CFG_LEVEL:       sustain_level <= cfg_data[LEVEL_BITS-1:0];
      endcase
      phase <= PH_ATTACK;
    end else if (cmd.decide) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      frame_r  <= frame_index;
      sample_r <= sample_in;
      last_r   <= last_in;
    end
    if (cmd.decide) begin
      kind    <= kind_next;
      operand <= operand_next;
      divisor <= divisor_next;
      gain    <= (kind_next == GK_LEVEL) ? level : '0;
    end
    if (cmd.mul) begin
      rem  <= ramp_prod[PROD_BITS-1:LEVEL_BITS];
      quot <= ramp_prod[LEVEL_BITS-1:0];
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? FRAME_BITS'(trial - {1'b0, divisor}) : trial[FRAME_BITS-1:0];
      quot <= {quot[LEVEL_BITS-2:0], trial_ge};
    end
    if (cmd.scale) begin
      scaled <= SCALE_BITS'(sample_r) * SCALE_BITS'($signed({1'b0, gain_sel}));
    end
    if (cmd.load_out) begin
      sample_out <= (kind == GK_PASS) ? sample_r
                                      : scaled[SAMPLE_BITS+LEVEL_BITS-2:LEVEL_BITS-1];
      finished   <= (kind == GK_PASS);
      last_out   <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/attack_sustain_decay_envelope.sv =====
// ----------------------------------------------------------------------------
// attack_sustain_decay_envelope
// Scales each audio sample by a linear attack, sustain and decay envelope
// driven by the frame number of the sample's block.
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_stall    frame_index, sample_in, last_in
//   output   out        out_valid / out_stall  sample_out, finished, last_out
//   config   in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A ramp sample reaches the output register through the ramp product and the
// 16-step serial divider; other samples go from the phase decision to scaling.
// One sample is in work at a time and the next is accepted in the cycle after
// the hand-off, even while the output is stalled.
// Reset is synchronous and clears the configuration to its defaults.
// A stalled output holds its transaction and delays only the next hand-off.
// ----------------------------------------------------------------------------
module attack_sustain_decay_envelope
  import asde_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAME_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [FRAME_BITS-1:0]         frame_index,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic                          last_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic                          finished,
  output logic                          last_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  cfg_index_t                    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  asde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  asde_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAME_BITS  (FRAME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .frame_index (frame_index),
    .sample_in   (sample_in),
    .last_in     (last_in),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .sample_out  (sample_out),
    .finished    (finished),
    .last_out    (last_out)
  );

endmodule

// ===== rtl/core/asde_checker.sv =====
// ----------------------------------------------------------------------------
// asde_checker
// Port-level checks on the envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
module asde_checker
  import asde_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAME_BITS  = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic                          finished,
  input logic                          cfg_ready
);

  // A stalled output transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(sample_out) && $stable(finished))
    else $error("stalled output transaction changed");

  // An accepted sample keeps the input side busy, so no second sample is taken right behind it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input taken again too early");

  // Reset leaves no output transaction pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // The configuration port never holds off a write.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind attack_sustain_decay_envelope asde_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .FRAME_BITS  (FRAME_BITS)
) u_asde_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .sample_out  (sample_out),
  .finished    (finished),
  .cfg_ready   (cfg_ready)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear envelope generator. A queue-fed driver
// offers samples with random idle gaps, and a monitor compares every output
// transaction against a cycle-free envelope predictor. The receiver stalls
// at random and, twice, for a long stretch. Configuration is rewritten
// between phases once the block has drained.
// ----------------------------------------------------------------------------
module testbench;
  import asde_pkg::*;

  localparam int SMP_W       = 16;
  localparam int FRM_W       = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [FRM_W-1:0] frame;
    logic [SMP_W-1:0] sample;
    logic             last;
  } env_in_t;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             finished;
    logic             last;
  } env_out_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [FRM_W-1:0]        frame_index = '0;
  logic signed [SMP_W-1:0] sample_in = '0;
  logic                    last_in = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [SMP_W-1:0] sample_out;
  logic                    finished;
  logic                    last_out;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  cfg_index_t              cfg_index = CFG_ATTACK_END;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  attack_sustain_decay_envelope #(
    .SAMPLE_BITS(SMP_W),
    .FRAME_BITS(FRM_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .frame_index(frame_index),
    .sample_in(sample_in),
    .last_in(last_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .finished(finished),
    .last_out(last_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predictor state, mirrored from the configuration writes.
  logic [FRM_W-1:0] env_attack_end  = '0;
  logic [FRM_W-1:0] env_decay_start = '0;
  logic [FRM_W-1:0] env_end         = '0;
  logic [15:0]      env_level       = UNITY;
  phase_t           env_phase       = PH_ATTACK;

  env_in_t  sample_feed_q[$];
  env_out_t scaled_q[$];
  env_in_t  offered;
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       tx_gap = 0;
  int       tx_calm = 0;
  int       rx_gap = 0;
  int       rx_calm = 0;
  int       hold_left = 0;
  int       out_seen = 0;
  int       random_sent = 0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic env_out_t predict_envelope(env_in_t item);
    logic [15:0]     lvl;
    longint unsigned gain;
    longint          prod;
    bit              have_gain;
    env_out_t        res;
    lvl = (env_level > UNITY) ? UNITY : env_level;
    gain = 0;
    have_gain = 1'b0;
    if (env_phase == PH_ATTACK) begin
      if (item.frame < env_attack_end) begin
        gain = (64'(lvl) * item.frame) / env_attack_end;
        have_gain = 1'b1;
      end else begin
        env_phase = PH_SUSTAIN;
      end
    end
    if (!have_gain && env_phase == PH_SUSTAIN) begin
      if (item.frame < env_decay_start) begin
        gain = lvl;
        have_gain = 1'b1;
      end else begin
        env_phase = PH_DECAY;
      end
    end
    if (!have_gain && env_phase == PH_DECAY) begin
      if (item.frame < env_end) begin
        if (item.frame >= env_decay_start) begin
          gain = (64'(lvl) * (env_end - item.frame)) / (env_end - env_decay_start);
        end
        have_gain = 1'b1;
      end else begin
        env_phase = PH_DONE;
      end
    end
    if (env_phase == PH_DONE) begin
      res.sample = item.sample;
    end else begin
      prod = longint'($signed(item.sample)) * longint'(gain);
      res.sample = SMP_W'(prod >>> 15);
    end
    res.finished = (env_phase == PH_DONE);
    res.last = item.last;
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : feed_driver
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
      tx_calm = 0;
    end else begin
      if (in_valid && !in_stall) begin
        scaled_q.push_back(predict_envelope(offered));
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (sample_feed_q.size() > 0) begin
          offered = sample_feed_q.pop_front();
          in_valid <= 1'b1;
          frame_index <= offered.frame;
          sample_in <= offered.sample;
          last_in <= offered.last;
          if (tx_calm > 0) begin
            tx_calm--;
          end else begin
            tx_gap = idle_len();
            if ($urandom_range(0, 149) == 0) tx_calm = 100;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The receiver counts its own transactions and holds off for a long
  // stretch at two points so that the block fills up and stalls its input.
  always @(posedge clk) begin : stall_gen
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_seen++;
        if (out_seen == 300 || out_seen == 1400) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_calm > 0) begin
        rx_calm--;
        out_stall <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        rx_gap = idle_len();
        if ($urandom_range(0, 199) == 0) rx_calm = 150;
      end
    end
  end

  always @(posedge clk) begin : out_monitor
    env_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (scaled_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no output transaction, actual sample_out %0d", $time,
                 sample_out);
      end else begin
        want = scaled_q.pop_front();
        if (sample_out !== want.sample) begin
          mismatch_count++;
          $display("%0t: sample_out expected %0d actual %0d", $time,
                   $signed(want.sample), sample_out);
        end
        if (finished !== want.finished) begin
          mismatch_count++;
          $display("%0t: finished expected %0b actual %0b", $time, want.finished,
                   finished);
        end
        if (last_out !== want.last) begin
          mismatch_count++;
          $display("%0t: last_out expected %0b actual %0b", $time, want.last, last_out);
        end
      end
    end
  end

  task automatic push_sample(logic [FRM_W-1:0] fr, logic [SMP_W-1:0] smp, logic lst);
    env_in_t item;
    item.frame = fr;
    item.sample = smp;
    item.last = lst;
    sample_feed_q.push_back(item);
  endtask

  task automatic wait_drained();
    while (sample_feed_q.size() != 0 || in_valid || scaled_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ATTACK_END:  env_attack_end = data;
      CFG_DECAY_START: env_decay_start = data;
      CFG_END:         env_end = data;
      CFG_LEVEL:       env_level = data[15:0];
      default: ;
    endcase
    env_phase = PH_ATTACK;
  endtask

  task automatic set_envelope(logic [31:0] a, logic [31:0] d, logic [31:0] e,
                              logic [31:0] lvl);
    logic [31:0] vals[4];
    int          rot;
    cfg_index_t  idx;
    vals[CFG_ATTACK_END] = a;
    vals[CFG_DECAY_START] = d;
    vals[CFG_END] = e;
    vals[CFG_LEVEL] = lvl;
    rot = $urandom_range(0, 3);
    for (int k = 0; k < 4; k++) begin
      idx = cfg_index_t'(rot + k);
      write_reg(idx, vals[idx]);
    end
  endtask

  task automatic random_phase();
    logic [31:0] base;
    logic [31:0] a;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] lvl;
    longint      fr;
    int          mode;
    int          count;
    int          blk;
    int          r;
    logic [15:0] smp;
    r = $urandom_range(0, 9);
    if (r < 5) base = 0;
    else if (r < 8) base = $urandom_range(0, 32'hFFFF_F000);
    else if (r == 8) base = 32'hFFFF_FF60;
    else base = 32'h7FFF_FFC0;
    mode = $urandom_range(0, 9);
    a = base + $urandom_range(0, 40);
    d = a + $urandom_range(0, 40);
    e = d + $urandom_range(0, 40);
    if (mode >= 7 && mode <= 8) begin
      a = base + $urandom_range(0, 100);
      d = base + $urandom_range(0, 100);
      e = base + $urandom_range(0, 100);
    end else if (mode == 9) begin
      a = ($urandom_range(0, 2) == 0) ? 32'h0 : (($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : a);
      d = ($urandom_range(0, 2) == 0) ? 32'h0 : (($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : d);
      e = ($urandom_range(0, 2) == 0) ? 32'h0 : (($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : e);
    end
    r = $urandom_range(0, 9);
    if (r < 3) lvl = UNITY;
    else if (r == 3) lvl = 0;
    else if (r < 8) lvl = $urandom_range(0, 32768);
    else lvl = $urandom_range(32769, 65535);
    if ($urandom_range(0, 3) == 0) lvl[31:16] = 16'($urandom);
    set_envelope(a, d, e, lvl);

    count = $urandom_range(40, 260);
    fr = base;
    while (count > 0) begin
      blk = $urandom_range(1, 8);
      for (int i = 0; i < blk && count > 0; i++) begin
        smp = 16'($urandom);
        if ($urandom_range(0, 15) == 0) smp = ($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7FFF;
        if ($urandom_range(0, 59) == 0) push_sample($urandom, smp, i == blk - 1);
        else push_sample(32'(fr), smp, i == blk - 1);
        count--;
        random_sent++;
      end
      if ($urandom_range(0, 29) == 0) begin
        r = $urandom_range(1, 20);
        if (fr >= r) fr = fr - r;
      end else begin
        fr = fr + $urandom_range(0, 4);
        if (fr > 64'hFFFF_FFFF) fr = 64'hFFFF_FFFF;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Default configuration: every span is empty, so the first sample ends
    // the envelope and samples pass through unscaled.
    push_sample(32'h0, 16'h8000, 1'b0);
    push_sample(32'hFFFF_FFFF, 16'h7FFF, 1'b1);
    push_sample(32'h0, 16'hFFFF, 1'b0);
    wait_drained();

    set_envelope(32'd8, 32'd16, 32'd24, UNITY);
    push_sample(32'd0, 16'h7FFF, 1'b0);
    push_sample(32'd4, 16'h8000, 1'b0);
    push_sample(32'd7, 16'hFFFF, 1'b1);
    push_sample(32'd8, 16'd1000, 1'b0);
    push_sample(32'd15, 16'h8000, 1'b0);
    push_sample(32'd16, 16'h7FFF, 1'b0);
    push_sample(32'd20, 16'hFFFD, 1'b1);
    push_sample(32'd3, 16'd12345, 1'b0);
    push_sample(32'd24, 16'hFFF9, 1'b0);
    push_sample(32'd5, 16'd99, 1'b1);
    wait_drained();

    // A level above unity, and a decay that starts before the attack ends.
    set_envelope(32'd10, 32'd5, 32'd20, 32'h0000_FFFF);
    push_sample(32'd2, 16'd20000, 1'b0);
    push_sample(32'd10, 16'hB1E0, 1'b0);
    push_sample(32'd2, 16'h7FFF, 1'b1);
    push_sample(32'd19, 16'h8000, 1'b0);
    push_sample(32'd20, 16'd1, 1'b1);
    wait_drained();

    set_envelope(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    push_sample(32'hFFFF_FFFE, 16'h8000, 1'b0);
    push_sample(32'hAAAA_5555, 16'h7FFF, 1'b1);
    wait_drained();

    set_envelope(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    push_sample(32'h5555_AAAA, 16'hFFFF, 1'b0);
    push_sample(32'hFFFF_FFFE, 16'h7FFF, 1'b1);
    wait_drained();

    while (random_sent < RANDOM_ITEMS) random_phase();

    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && scaled_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
